[rtl/bsr_pkg.sv]
package bsr_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned IDX_W    = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned PEND_W   = 17;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_EMPTY = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_IDX,
    ST_DIFF,
    ST_LO,
    ST_WIN,
    ST_AD,
    ST_MARK,
    ST_ADV_REQ,
    ST_ADV_CHK,
    ST_END_ADD,
    ST_END_SUB,
    ST_END_CAP,
    ST_RD_POP,
    ST_RD_DATA,
    ST_DONE
  } bsr_state_e;

endpackage

[rtl/byte_stream_reassembler.sv]
// Channel | Direction | Handshake               | Beat payload
// in      | input     | in_valid_i / in_ready_o   | mode, seg_start, seg_len, byte_offset,
//         |           |                           | data_byte, end_flag
// out     | output    | out_valid_o / out_ready_i | read_byte, read_valid, assembled_end,
//         |           |                           | pending_count, stream_done
//
// Accept to result: a byte inside the window is stored, then the assembled point moves
// over the marked slots ahead of it (one a cycle); the end mark is checked if due.
// A byte outside the window skips the advance but may still check the end mark; a read,
// an empty segment and the unused mode each take their own path to the result.
// Reset: a clearing pass zeroes one valid mark a cycle, in_ready_o low.
// Stalls: one beat at a time; a result waiting in the output register holds the next.
module byte_stream_reassembler
  import bsr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [IDX_W-1:0]  seg_start_i,
  input  logic [LEN_W-1:0]  seg_len_i,
  input  logic [LEN_W-1:0]  byte_offset_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_flag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_byte_o,
  output logic              read_valid_o,
  output logic [IDX_W-1:0]  assembled_end_o,
  output logic [PEND_W-1:0] pending_count_o,
  output logic              stream_done_o
);

  bsr_state_e state_q, state_d;

  // latched beat
  logic [1:0]        mode_q;
  logic [IDX_W-1:0]  start_q;
  logic [LEN_W-1:0]  len_q, off_q;
  logic [7:0]        byte_q;
  logic              eflag_q;

  // scratch: stream index, window offset, general temp
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  d_q, d_d;
  logic [IDX_W-1:0]  t_q, t_d;

  // architectural state
  logic [IDX_W-1:0]  ap_q, ap_d;
  logic [IDX_W-1:0]  rp_q, rp_d;
  logic [IDX_W-1:0]  sb_q, sb_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              end_q, end_d;
  logic [SLOT_W-1:0] clr_q, clr_d;

  logic [7:0]        rbyte_q, rbyte_d;
  logic              rvalid_q, rvalid_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        read_byte_q;
  logic              read_valid_q;
  logic [IDX_W-1:0]  assembled_end_q;
  logic [PEND_W-1:0] pending_count_q;
  logic              stream_done_q;
  logic              out_load;

  // shared adder/subtractor
  logic [IDX_W-1:0]  alu_a, alu_b;
  logic              alu_sub, alu_inc;
  logic [IDX_W:0]    alu_sum;
  logic              alu_carry;

  // ring ports
  logic              d_we, d_re;
  logic [SLOT_W-1:0] d_waddr, d_raddr;
  logic [7:0]        d_rdata;
  logic              v_we, v_re;
  logic [SLOT_W-1:0] v_waddr, v_raddr;
  logic [0:0]        v_wdata, v_rdata;

  logic              accept;
  logic              end_chk;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // end mark evaluated on the last byte of a segment or on an empty segment
  assign end_chk = eflag_q && ((mode_q == MODE_EMPTY) ||
                   ((len_q != '0) && (off_q == len_q - 16'd1)));

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{IDX_W{1'b0}}, (alu_sub || alu_inc)};
  assign alu_carry = alu_sum[IDX_W];

  bsr_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (byte_q),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  bsr_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    d_d         = d_q;
    t_d         = t_q;
    ap_d        = ap_q;
    rp_d        = rp_q;
    sb_d        = sb_q;
    pend_d      = pend_q;
    end_d       = end_q;
    clr_d       = clr_q;
    rbyte_d     = rbyte_q;
    rvalid_d    = rvalid_q;
    out_load    = 1'b0;
    alu_a       = ap_q;
    alu_b       = '0;
    alu_sub     = 1'b0;
    alu_inc     = 1'b0;
    d_we        = 1'b0;
    d_re        = 1'b0;
    d_waddr     = idx_q[SLOT_W-1:0];
    d_raddr     = rp_q[SLOT_W-1:0];
    v_we        = 1'b0;
    v_re        = 1'b0;
    v_waddr     = idx_q[SLOT_W-1:0];
    v_raddr     = idx_q[SLOT_W-1:0];
    v_wdata     = 1'b0;

    case (state_q)
      ST_CLR: begin
        v_we    = 1'b1;
        v_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == SLOT_W'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rbyte_d  = '0;
          rvalid_d = 1'b0;
          case (mode_i)
            MODE_BYTE: begin
              if (byte_offset_i == '0) begin
                sb_d = ap_q;
              end
              state_d = ST_IDX;
            end
            MODE_EMPTY: begin
              sb_d    = ap_q;
              state_d = ST_END_ADD;
            end
            MODE_READ: state_d = ST_RD_POP;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_IDX: begin
        alu_a   = start_q;
        alu_b   = {{(IDX_W-LEN_W){1'b0}}, off_q};
        idx_d   = alu_sum[IDX_W-1:0];
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        alu_a   = idx_q;
        alu_b   = rp_q;
        alu_sub = 1'b1;
        d_d     = alu_sum[IDX_W-1:0];
        state_d = ST_LO;
      end
      ST_LO: begin
        alu_a   = sb_q;
        alu_b   = rp_q;
        alu_sub = 1'b1;
        t_d     = alu_sum[IDX_W-1:0];
        state_d = ST_WIN;
      end
      ST_WIN: begin
        // d >= lo and d < CAPACITY: store the byte, fetch its mark
        alu_a   = d_q;
        alu_b   = t_q;
        alu_sub = 1'b1;
        if (alu_carry && (d_q < IDX_W'(CAPACITY))) begin
          d_we    = 1'b1;
          v_re    = 1'b1;
          state_d = ST_AD;
        end else begin
          state_d = end_chk ? ST_END_ADD : ST_DONE;
        end
      end
      ST_AD: begin
        alu_a   = ap_q;
        alu_b   = rp_q;
        alu_sub = 1'b1;
        t_d     = alu_sum[IDX_W-1:0];
        state_d = ST_MARK;
      end
      ST_MARK: begin
        // not yet assembled and not already pending: mark and count it
        alu_a   = d_q;
        alu_b   = t_q;
        alu_sub = 1'b1;
        if (alu_carry && !v_rdata[0]) begin
          v_we    = 1'b1;
          v_wdata = 1'b1;
          pend_d  = pend_q + 1'b1;
        end
        state_d = ST_ADV_REQ;
      end
      ST_ADV_REQ: begin
        v_re    = 1'b1;
        v_raddr = ap_q[SLOT_W-1:0];
        state_d = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        // mark at ap is in v_rdata; retire it and look one slot ahead
        alu_a   = ap_q;
        alu_inc = 1'b1;
        if (v_rdata[0]) begin
          v_we    = 1'b1;
          v_waddr = ap_q[SLOT_W-1:0];
          v_wdata = 1'b0;
          if (pend_q != '0) begin
            pend_d = pend_q - 1'b1;
          end
          ap_d    = alu_sum[IDX_W-1:0];
          v_re    = 1'b1;
          v_raddr = alu_sum[SLOT_W-1:0];
        end else begin
          state_d = end_chk ? ST_END_ADD : ST_DONE;
        end
      end
      ST_END_ADD: begin
        alu_a   = start_q;
        alu_b   = (mode_q == MODE_EMPTY) ? '0 : {{(IDX_W-LEN_W){1'b0}}, len_q};
        t_d     = alu_sum[IDX_W-1:0];
        state_d = ST_END_SUB;
      end
      ST_END_SUB: begin
        alu_a   = t_q;
        alu_b   = rp_q;
        alu_sub = 1'b1;
        t_d     = alu_sum[IDX_W-1:0];
        state_d = ST_END_CAP;
      end
      ST_END_CAP: begin
        // serial compare: end <= read point + capacity, only with the end flag set
        alu_a   = t_q;
        alu_b   = IDX_W'(CAPACITY);
        alu_sub = 1'b1;
        if (eflag_q && ((alu_sum[IDX_W-1:0] == '0) || alu_sum[IDX_W-1])) begin
          end_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_RD_POP: begin
        alu_a   = rp_q;
        alu_inc = 1'b1;
        if (rp_q != ap_q) begin
          d_re    = 1'b1;
          rp_d    = alu_sum[IDX_W-1:0];
          state_d = ST_RD_DATA;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RD_DATA: begin
        rbyte_d  = d_rdata;
        rvalid_d = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ap_q        <= '0;
      rp_q        <= '0;
      sb_q        <= '0;
      pend_q      <= '0;
      end_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ap_q        <= ap_d;
      rp_q        <= rp_d;
      sb_q        <= sb_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      start_q <= seg_start_i;
      len_q   <= seg_len_i;
      off_q   <= byte_offset_i;
      byte_q  <= data_byte_i;
      eflag_q <= end_flag_i;
    end
    idx_q    <= idx_d;
    d_q      <= d_d;
    t_q      <= t_d;
    rbyte_q  <= rbyte_d;
    rvalid_q <= rvalid_d;
    if (out_load) begin
      read_byte_q     <= rbyte_q;
      read_valid_q    <= rvalid_q;
      assembled_end_q <= ap_q;
      pending_count_q <= pend_q;
      stream_done_q   <= end_q && (pend_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_byte_o     = read_byte_q;
  assign read_valid_o    = read_valid_q;
  assign assembled_end_o = assembled_end_q;
  assign pending_count_o = pending_count_q;
  assign stream_done_o   = stream_done_q;

  // pending bytes all live in the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(CAPACITY))
    else $error("pending count above capacity");

  // read point never runs past the assembled point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ap_q - rp_q) <= IDX_W'(CAPACITY))
    else $error("assembled point outside window");

  // one beat at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("beat taken while busy");

  // a result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // done status implies nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> (pending_count_o == '0))
    else $error("done with bytes pending");

endmodule

[rtl/bsr_ram.sv]
module bsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bsr_pkg::*;

  // Mode code the block does not use; it only reports status for it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles with no beat on either channel before the run is declared hung.
  // Slowest legal gap: the clearing pass after reset or an advance over a full
  // ring, plus handshake stalls; taken several times.
  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int unsigned TARGET_BEATS = 1350;
  localparam int unsigned MAX_PRINTS   = 100;
  localparam int unsigned TAIL_CYCLES  = 30;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] off;
    logic [7:0]       data;
    logic             eflag;
  } beat_t;

  typedef struct packed {
    logic [7:0]        rbyte;
    logic              rvalid;
    logic [IDX_W-1:0]  asm_end;
    logic [PEND_W-1:0] pend;
    logic              done;
  } status_t;

  // One row of the directed script; typed rows carry their own expectation.
  typedef struct {
    beat_t   b;
    bit      typed;
    status_t want;
  } row_t;

  localparam status_t ZERO_STATUS = '0;

  // ---------------------------------------------------------------- DUT I/O
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        mode_i        = MODE_READ;
  logic [IDX_W-1:0]  seg_start_i   = '0;
  logic [LEN_W-1:0]  seg_len_i     = '0;
  logic [LEN_W-1:0]  byte_offset_i = '0;
  logic [7:0]        data_byte_i   = '0;
  logic              end_flag_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [7:0]        read_byte_o;
  logic              read_valid_o;
  logic [IDX_W-1:0]  assembled_end_o;
  logic [PEND_W-1:0] pending_count_o;
  logic              stream_done_o;

  byte_stream_reassembler dut (.*);

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------ stream predictor
  // Own copy of the reassembler state, advanced once per accepted in beat.
  logic [7:0]        ring_data [CAPACITY];
  bit                ring_mark [CAPACITY];
  logic [IDX_W-1:0]  asm_pt;
  logic [IDX_W-1:0]  rd_pt;
  logic [IDX_W-1:0]  seg_base;
  logic [PEND_W-1:0] pend_cnt;
  bit                end_mark;

  status_t     status_q [$];   // expected out beats, oldest first
  row_t        script [$];
  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          src_calm    = 1'b0;
  bit          snk_calm    = 1'b0;

  function automatic logic [SLOT_W-1:0] slot_of(logic [IDX_W-1:0] idx);
    return SLOT_W'(idx % CAPACITY);
  endfunction

  // End mark sticks only if the segment end fits in the window
  // (wrapping serial compare against read pointer + capacity).
  function automatic void check_end(logic [IDX_W-1:0] start, logic [IDX_W-1:0] len,
                                    bit flag);
    logic [IDX_W-1:0] diff;
    diff = start + len - (rd_pt + CAPACITY);
    if (flag && (diff == '0 || diff[IDX_W-1])) end_mark = 1'b1;
  endfunction

  function automatic status_t reassemble_step(beat_t b);
    status_t          r;
    logic [IDX_W-1:0] idx, d, lo, ad;
    logic [SLOT_W-1:0] s;
    int unsigned      n;
    r = '0;
    case (b.mode)
      MODE_BYTE: begin
        idx = b.start + IDX_W'(b.off);
        if (b.off == '0) seg_base = asm_pt;
        d  = idx - rd_pt;
        lo = seg_base - rd_pt;
        ad = asm_pt - rd_pt;
        if (d >= lo && d < CAPACITY) begin
          s = slot_of(idx);
          ring_data[s] = b.data;           // newest byte wins
          if (d >= ad && !ring_mark[s]) begin
            ring_mark[s] = 1'b1;
            pend_cnt++;
          end
          // walk the assembled point over contiguous marked slots
          n = 0;
          while (n < CAPACITY && ring_mark[slot_of(asm_pt)]) begin
            ring_mark[slot_of(asm_pt)] = 1'b0;
            if (pend_cnt != '0) pend_cnt--;
            asm_pt++;
            n++;
          end
        end
        if (b.len != '0 && b.off == b.len - 1) check_end(b.start, IDX_W'(b.len), b.eflag);
      end
      MODE_EMPTY: begin
        seg_base = asm_pt;
        check_end(b.start, '0, b.eflag);
      end
      MODE_READ: begin
        if (rd_pt != asm_pt) begin
          r.rbyte  = ring_data[slot_of(rd_pt)];
          r.rvalid = 1'b1;
          rd_pt++;
        end
      end
      default: ;
    endcase
    r.asm_end = asm_pt;
    r.pend    = pend_cnt;
    r.done    = end_mark && pend_cnt == '0;
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic beat_t make_beat(logic [1:0] mode, logic [IDX_W-1:0] start,
                                      logic [LEN_W-1:0] len, logic [LEN_W-1:0] off,
                                      logic [7:0] data, logic eflag);
    beat_t b;
    b = '{mode: mode, start: start, len: len, off: off, data: data, eflag: eflag};
    return b;
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [IDX_W-1:0] start,
                                  logic [LEN_W-1:0] len, logic [LEN_W-1:0] off,
                                  logic [7:0] data, logic eflag, bit typed, status_t want);
    row_t r;
    r.b     = make_beat(mode, start, len, off, data, eflag);
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  // Stream content is a function of the index, so overlaps mostly agree;
  // now and then a different byte shows that the newest one wins.
  function automatic logic [7:0] stream_byte(logic [IDX_W-1:0] idx);
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return (idx[7:0] * 8'd37) ^ idx[15:8];
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("tb: mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Drives one in beat starting at a falling edge, returns at the falling edge
  // after it was taken. Valid drops only when a gap is drawn.
  task automatic send_beat(beat_t b, bit typed, status_t want);
    int unsigned gap;
    status_t     pred;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i        = b.mode;
    seg_start_i   = b.start;
    seg_len_i     = b.len;
    byte_offset_i = b.off;
    data_byte_i   = b.data;
    end_flag_i    = b.eflag;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = reassemble_step(b);
    status_q.push_back(typed ? want : pred);
    if (b.mode != MODE_UNUSED) beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_seg_byte(logic [IDX_W-1:0] start, logic [LEN_W-1:0] len,
                               logic [LEN_W-1:0] off, logic eflag);
    send_beat(make_beat(MODE_BYTE, start, len, off, stream_byte(start + IDX_W'(off)), eflag),
              1'b0, ZERO_STATUS);
  endtask

  // True when a segment end lies past the window, so its end mark is dropped.
  function automatic bit end_is_cut(logic [IDX_W-1:0] start, logic [LEN_W-1:0] len);
    logic [IDX_W-1:0] diff;
    diff = start + IDX_W'(len) - (rd_pt + CAPACITY);
    return diff != '0 && !diff[IDX_W-1];
  endfunction

  // ------------------------------------------------------------ out checker
  always @(posedge clk_i) begin : check_out
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, assembled_end %0h",
                                  assembled_end_o));
      end else begin
        want = status_q.pop_front();
        if (read_byte_o !== want.rbyte)
          report_mismatch($sformatf("read_byte %0h, want %0h", read_byte_o, want.rbyte));
        if (read_valid_o !== want.rvalid)
          report_mismatch($sformatf("read_valid %0b, want %0b", read_valid_o, want.rvalid));
        if (assembled_end_o !== want.asm_end)
          report_mismatch($sformatf("assembled_end %0h, want %0h", assembled_end_o,
                                    want.asm_end));
        if (pending_count_o !== want.pend)
          report_mismatch($sformatf("pending_count %0d, want %0d", pending_count_o,
                                    want.pend));
        if (stream_done_o !== want.done)
          report_mismatch($sformatf("stream_done %0b, want %0b", stream_done_o, want.done));
      end
      results_seen++;
    end
  end

  // Out side: random stall before each beat, with calm stretches at full rate.
  initial begin : out_sink
    int unsigned stall;
    @(negedge clk_i);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Watchdog on cycles without any beat; covers the drain at the end too.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin : stimulus
    beat_t            b;
    int unsigned      pick, kind, burst, variant, cut_at;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    bit               late, fin_flag, descend;

    for (int i = 0; i < CAPACITY; i++) begin
      ring_data[i] = '0;
      ring_mark[i] = 1'b0;
    end
    asm_pt   = '0;
    rd_pt    = '0;
    seg_base = '0;
    pend_cnt = '0;
    end_mark = 1'b0;

    // Directed script. Fresh state: all status fields zero.
    // read with nothing assembled
    add_row(MODE_READ, '0, '0, '0, 8'h00, 1'b0, 1'b1, ZERO_STATUS);
    // unused mode, every field at its top value: status only
    add_row(MODE_UNUSED, '1, '1, '1, 8'hff, 1'b1, 1'b1, ZERO_STATUS);
    // empty segment whose end sits one past the window: end mark dropped
    add_row(MODE_EMPTY, 32'h0000_1001, '0, '0, 8'h00, 1'b1, 1'b1, ZERO_STATUS);
    add_row(MODE_EMPTY, '1, '1, '1, 8'hff, 1'b0, 1'b1, ZERO_STATUS);
    // in-order first byte, then a pending one and its overwrite
    add_row(MODE_BYTE, '0, 16'd4, 16'd0, 8'h00, 1'b0, 1'b1,
            status_t'{8'h00, 1'b0, 32'd1, 17'd0, 1'b0});
    add_row(MODE_BYTE, '0, 16'd4, 16'd2, 8'hff, 1'b0, 1'b1,
            status_t'{8'h00, 1'b0, 32'd1, 17'd1, 1'b0});
    add_row(MODE_BYTE, '0, 16'd4, 16'd2, 8'h5a, 1'b0, 1'b1,
            status_t'{8'h00, 1'b0, 32'd1, 17'd1, 1'b0});
    // last byte of segment with end flag low, then the gap fill
    add_row(MODE_BYTE, '0, 16'd4, 16'd3, 8'ha5, 1'b0, 1'b0, ZERO_STATUS);
    add_row(MODE_BYTE, '0, 16'd4, 16'd1, 8'h3c, 1'b0, 1'b0, ZERO_STATUS);
    // rewrite of an already assembled byte inside the same segment
    add_row(MODE_BYTE, '0, 16'd4, 16'd1, 8'hc3, 1'b0, 1'b0, ZERO_STATUS);
    // retransmission: new segment start latches base past it, byte dropped
    add_row(MODE_BYTE, '0, 16'd4, 16'd0, 8'h77, 1'b0, 1'b0, ZERO_STATUS);
    // offset beyond length still lands at start + offset
    add_row(MODE_BYTE, '0, 16'd2, 16'd9, 8'h99, 1'b0, 1'b0, ZERO_STATUS);
    repeat (5) add_row(MODE_READ, '1, '1, '1, 8'hff, 1'b1, 1'b0, ZERO_STATUS);
    // read pointer now 4: byte at read + capacity is cut
    add_row(MODE_BYTE, 32'd4100, 16'd8, 16'd0, 8'h11, 1'b0, 1'b0, ZERO_STATUS);
    // last byte cut and end one past the window: end mark dropped
    add_row(MODE_BYTE, 32'd4093, 16'd8, 16'd7, 8'h22, 1'b1, 1'b0, ZERO_STATUS);
    // last slot of the window is kept
    add_row(MODE_BYTE, 32'd4099, 16'd1, 16'd0, 8'hff, 1'b0, 1'b0, ZERO_STATUS);
    // wrapped index far outside the window
    add_row(MODE_BYTE, '1, '1, '1, 8'hff, 1'b1, 1'b0, ZERO_STATUS);
    // zero-length byte segment: end flag never looked at
    add_row(MODE_BYTE, 32'h1234_5678, '0, '0, 8'h00, 1'b1, 1'b0, ZERO_STATUS);
    add_row(MODE_READ, '0, '0, '0, 8'h00, 1'b0, 1'b0, ZERO_STATUS);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) send_beat(script[i].b, script[i].typed, script[i].want);

    // Random part. Early on end flags only ride on segments cut by the
    // window, so the end mark stays clear; later kept ends show up too.
    while (beats_sent < TARGET_BEATS + script.size()) begin
      pick = $urandom_range(0, 99);
      late = beats_sent > (TARGET_BEATS * 2) / 3;
      if (pick < 25) begin
        // read burst; drain harder when the window is nearly full
        burst = (asm_pt - rd_pt > 2000) ? $urandom_range(8, 24) : $urandom_range(1, 10);
        repeat (burst)
          send_beat(make_beat(MODE_READ, $urandom, LEN_W'($urandom), LEN_W'($urandom),
                              8'($urandom), 1'($urandom)),
                    1'b0, ZERO_STATUS);
      end else if (pick < 85) begin
        // well-formed segment: offset 0 first, the rest in either order
        len = ($urandom_range(0, 15) == 0) ? LEN_W'($urandom_range(13, 80))
                                           : LEN_W'($urandom_range(1, 12));
        kind = $urandom_range(0, 9);
        if (kind < 2)      start = asm_pt - $urandom_range(1, 16);
        else if (kind < 5) start = asm_pt;
        else if (kind < 8) start = asm_pt + $urandom_range(1, 48);
        else if (kind < 9) start = asm_pt + $urandom_range(200, 3000);
        else               start = rd_pt + CAPACITY - len + $urandom_range(0, 2) - 1;
        fin_flag = late ? ($urandom_range(0, 3) == 0) : end_is_cut(start, len);
        descend  = $urandom_range(0, 3) == 0;
        send_seg_byte(start, len, '0, (len == 1) ? fin_flag : 1'($urandom));
        for (int o = 1; o < len; o++) begin
          variant = descend ? len - o : o;
          send_seg_byte(start, len, LEN_W'(variant),
                        (variant == len - 1) ? fin_flag : 1'($urandom));
        end
      end else if (pick < 90) begin
        // empty segment
        start = ($urandom_range(0, 1) == 0) ? asm_pt + $urandom_range(0, 40)
                                            : rd_pt + CAPACITY + $urandom_range(0, 2) - 1;
        fin_flag = late ? ($urandom_range(0, 1) == 0) : end_is_cut(start, '0);
        send_beat(make_beat(MODE_EMPTY, start, LEN_W'($urandom), LEN_W'($urandom),
                            8'($urandom), fin_flag),
                  1'b0, ZERO_STATUS);
      end else if (pick < 95) begin
        // broken segment: no first byte, truncated, or offset past length
        len     = LEN_W'($urandom_range(2, 12));
        start   = asm_pt + $urandom_range(0, 24);
        variant = $urandom_range(0, 2);
        if (variant == 0) begin
          for (int o = 1; o < len; o++) send_seg_byte(start, len, LEN_W'(o), 1'b0);
        end else if (variant == 1) begin
          cut_at = $urandom_range(1, len - 1);
          for (int o = 0; o < cut_at; o++) send_seg_byte(start, len, LEN_W'(o), 1'($urandom));
        end else begin
          send_seg_byte(start, len, '0, 1'b0);
          send_seg_byte(start, len, len + LEN_W'($urandom_range(0, 40)), 1'($urandom));
        end
      end else begin
        // noise: every field drawn over its whole range
        b = make_beat(2'($urandom_range(0, 3)), $urandom, LEN_W'($urandom), LEN_W'($urandom),
                      8'($urandom), 1'($urandom));
        if (!late && end_is_cut(b.start, (b.mode == MODE_EMPTY) ? '0 : b.len) == 1'b0)
          b.eflag = 1'b0;
        send_beat(b, 1'b0, ZERO_STATUS);
      end
    end
    in_valid_i = 1'b0;

    while (status_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bsr_pkg.sv
rtl/bsr_ram.sv
rtl/byte_stream_reassembler.sv
sim/tb_top.sv
